// File: rtl/core/ftpnd_pkg.sv
// ----------------------------------------------------------------------------
// ftpnd_pkg
// Shared types and constants for the fit-to-page nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
package ftpnd_pkg;

    localparam int PIXEL_BITS   = 8;
    localparam int GUARD_BITS   = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int QUEUE_DEPTH  = 4;

    // Register reset values
    localparam int PAGE_WIDTH_RESET    = 600;
    localparam int PAGE_HEIGHT_RESET   = 800;
    localparam int GUARD_SIZE_RESET    = 0;
    localparam int SOURCE_WIDTH_RESET  = 1;
    localparam int SOURCE_HEIGHT_RESET = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PAGE_WIDTH    = 3'd0,
        REG_PAGE_HEIGHT   = 3'd1,
        REG_GUARD_SIZE    = 3'd2,
        REG_SOURCE_WIDTH  = 3'd3,
        REG_SOURCE_HEIGHT = 3'd4
    } cfg_reg_t;

    // Position marks of one source pixel
    typedef struct packed {
        logic row_end;
        logic frame_end;
    } pos_flags_t;

    // One queued source item
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        pos_flags_t            flags;
    } queue_item_t;

    localparam int ITEM_BITS = $bits(queue_item_t);

    // Back end sequencing
    typedef enum logic [1:0] {
        BK_NEED_FIT,
        BK_WAIT_FIT,
        BK_STREAM
    } back_state_t;

    // Fit size calculator sequencing
    typedef enum logic [2:0] {
        FT_IDLE,
        FT_MUL,
        FT_DIV,
        FT_CHECK,
        FT_DONE
    } fit_state_t;

endpackage

// File: rtl/core/ftpnd_queue.sv
// ----------------------------------------------------------------------------
// ftpnd_queue
// Small register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module ftpnd_queue #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/ftpnd_front.sv
// ----------------------------------------------------------------------------
// ftpnd_front
// Accepts source pixels, follows the raster position and marks row and
// frame ends before the item enters the queue.
// ----------------------------------------------------------------------------
module ftpnd_front #(
    parameter int DIM_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ftpnd_pkg::PIXEL_BITS-1:0] pixel_in,
    input  logic [DIM_BITS-1:0]            sw_eff,
    input  logic [DIM_BITS-1:0]            sh_eff,
    input  logic                           queue_full,
    output logic                           push,
    output ftpnd_pkg::queue_item_t         push_item
);

    import ftpnd_pkg::*;

    logic [DIM_BITS-1:0] src_col_reg, src_col_next;
    logic [DIM_BITS-1:0] src_row_reg, src_row_next;
    logic                row_end;
    logic                frame_end;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Classify position within the frame
    assign row_end   = ({1'b0, src_col_reg} + 1'b1) >= {1'b0, sw_eff};
    assign frame_end = row_end && (({1'b0, src_row_reg} + 1'b1) >= {1'b0, sh_eff});

    always_comb
    begin
        push_item.pixel           = pixel_in;
        push_item.flags.row_end   = row_end;
        push_item.flags.frame_end = frame_end;
    end

    // Advance raster position
    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        if (push)
        begin
            if (frame_end)
            begin
                src_col_next = '0;
                src_row_next = '0;
            end
            else if (row_end)
            begin
                src_col_next = '0;
                src_row_next = src_row_reg + 1'b1;
            end
            else
            begin
                src_col_next = src_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
        end
        else
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
        end
    end

endmodule

// File: rtl/core/ftpnd_fit.sv
// ----------------------------------------------------------------------------
// ftpnd_fit
// Works out the fitted frame size: one registered multiply and a restoring
// divider, one quotient bit per cycle, run at most twice per frame.
// ----------------------------------------------------------------------------
module ftpnd_fit #(
    parameter int DIM_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [DIM_BITS-1:0]             sw,
    input  logic [DIM_BITS-1:0]             sh,
    input  logic [DIM_BITS-1:0]             pw,
    input  logic [DIM_BITS-1:0]             ph,
    input  logic [ftpnd_pkg::GUARD_BITS-1:0] guard,
    output logic                            done,
    output logic [DIM_BITS-1:0]             fit_w,
    output logic [DIM_BITS-1:0]             fit_h
);

    import ftpnd_pkg::*;

    localparam int PROD_BITS = 2 * DIM_BITS;
    localparam int CNT_BITS  = $clog2(PROD_BITS);

    fit_state_t            state_reg, state_next;
    logic                  dir_reg;      // 0: width fixed, solve height
    logic                  second_reg;
    logic [DIM_BITS-1:0]   fixed_reg;
    logic [PROD_BITS-1:0]  quo_reg;
    logic [DIM_BITS-1:0]   rem_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [DIM_BITS-1:0]   w_reg;
    logic [DIM_BITS-1:0]   h_reg;

    logic [DIM_BITS-1:0]   guard_ext;
    logic [DIM_BITS-1:0]   shrink_w;
    logic [DIM_BITS-1:0]   shrink_h;
    logic                  wide;
    logic                  tall;
    logic [DIM_BITS-1:0]   mul_a;
    logic [DIM_BITS-1:0]   divisor;
    logic [DIM_BITS-1:0]   limit;
    logic                  over;
    logic [DIM_BITS:0]     rem_shift;
    logic                  rem_ge;
    logic                  div_last;

    // Shrunk page sizes saturate at zero
    assign guard_ext = DIM_BITS'(guard);
    assign shrink_w  = (pw > guard_ext) ? pw - guard_ext : '0;
    assign shrink_h  = (ph > guard_ext) ? ph - guard_ext : '0;
    assign wide      = sw > pw;
    assign tall      = sh > ph;

    // Operands of the current pass
    assign mul_a    = dir_reg ? sw : sh;
    assign divisor  = dir_reg ? sh : sw;
    assign limit    = dir_reg ? pw : ph;
    assign over     = quo_reg > PROD_BITS'(limit);
    assign div_last = (cnt_reg == CNT_BITS'(PROD_BITS - 1));

    // Restoring divide step
    assign rem_shift = {rem_reg, quo_reg[PROD_BITS-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FT_IDLE:
            begin
                if (start)
                begin
                    state_next = (wide || tall) ? FT_MUL : FT_DONE;
                end
            end
            FT_MUL:   state_next = FT_DIV;
            FT_DIV:
            begin
                if (div_last)
                begin
                    state_next = FT_CHECK;
                end
            end
            FT_CHECK: state_next = (!second_reg && over) ? FT_MUL : FT_DONE;
            FT_DONE:  state_next = FT_IDLE;
            default:  state_next = FT_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        done  = (state_reg == FT_DONE);
        fit_w = w_reg;
        fit_h = h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FT_IDLE;
            dir_reg    <= 1'b0;
            second_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                FT_IDLE:
                begin
                    dir_reg    <= !wide;
                    second_reg <= 1'b0;
                end
                FT_MUL:   cnt_reg <= '0;
                FT_DIV:   cnt_reg <= cnt_reg + 1'b1;
                FT_CHECK:
                begin
                    if (!second_reg && over)
                    begin
                        dir_reg    <= !dir_reg;
                        second_reg <= 1'b1;
                    end
                end
                default:  cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Datapath: fixed side, product, divider, result
    always_ff @(posedge clk)
    begin
        case (state_reg)
            FT_IDLE:
            begin
                fixed_reg <= wide ? shrink_w : shrink_h;
                w_reg     <= sw;
                h_reg     <= sh;
            end
            FT_MUL:
            begin
                quo_reg <= PROD_BITS'(mul_a) * PROD_BITS'(fixed_reg);
                rem_reg <= '0;
            end
            FT_DIV:
            begin
                if (rem_ge)
                begin
                    rem_reg <= DIM_BITS'(rem_shift - {1'b0, divisor});
                    quo_reg <= {quo_reg[PROD_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift[DIM_BITS-1:0];
                    quo_reg <= {quo_reg[PROD_BITS-2:0], 1'b0};
                end
            end
            FT_CHECK:
            begin
                if (!second_reg && over)
                begin
                    // Other side overflows: fix that side instead
                    fixed_reg <= dir_reg ? shrink_w : shrink_h;
                end
                else if (dir_reg)
                begin
                    h_reg <= fixed_reg;
                    w_reg <= quo_reg[DIM_BITS-1:0];
                end
                else
                begin
                    w_reg <= fixed_reg;
                    h_reg <= quo_reg[DIM_BITS-1:0];
                end
            end
            default:
            begin
                fixed_reg <= fixed_reg;
            end
        endcase
    end

endmodule

// File: rtl/core/ftpnd_back.sv
// ----------------------------------------------------------------------------
// ftpnd_back
// Takes queued source pixels, starts the fit calculation at each frame
// start and selects the nearest-neighbor pixels into the output register.
// ----------------------------------------------------------------------------
module ftpnd_back #(
    parameter int DIM_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  ftpnd_pkg::queue_item_t          head_item,
    output logic                            pop,
    input  logic [DIM_BITS-1:0]             sw_eff,
    input  logic [DIM_BITS-1:0]             sh_eff,
    output logic                            fit_start,
    input  logic                            fit_done,
    input  logic [DIM_BITS-1:0]             fit_w,
    input  logic [DIM_BITS-1:0]             fit_h,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ftpnd_pkg::PIXEL_BITS-1:0] pixel_out,
    output logic                            frame_last,
    output logic [DIM_BITS-1:0]             fitted_width,
    output logic [DIM_BITS-1:0]             fitted_height
);

    import ftpnd_pkg::*;

    localparam int ACC_BITS  = 2 * DIM_BITS;
    localparam int BASE_BITS = 2 * DIM_BITS + 1;

    back_state_t            state_reg, state_next;
    logic [DIM_BITS-1:0]    fw_reg;
    logic [DIM_BITS-1:0]    fh_reg;
    logic [DIM_BITS-1:0]    out_row_reg;
    logic [DIM_BITS-1:0]    out_col_reg;
    logic [ACC_BITS-1:0]    row_accum_reg;
    logic [ACC_BITS-1:0]    col_accum_reg;
    logic [BASE_BITS-1:0]   row_base_reg;   // src_row * fitted height
    logic [BASE_BITS-1:0]   col_base_reg;   // src_col * fitted width

    logic                   out_valid_reg;
    logic [PIXEL_BITS-1:0]  pixel_reg;
    logic                   last_reg;
    logic [DIM_BITS-1:0]    width_reg;
    logic [DIM_BITS-1:0]    height_reg;

    logic                   step;
    logic                   row_sel;
    logic                   hit;
    logic [BASE_BITS-1:0]   row_acc_ext;
    logic [BASE_BITS-1:0]   col_acc_ext;
    logic [BASE_BITS-1:0]   row_hi;
    logic [BASE_BITS-1:0]   col_hi;
    logic                   is_last;

    // Take the head item when the output slot is free or being taken
    assign step = (state_reg == BK_STREAM) && head_valid && (!out_valid_reg || !out_stall);

    // Source row/col match floor(accum / fitted) when accum lies in [base, base + fitted)
    assign row_acc_ext = BASE_BITS'(row_accum_reg);
    assign col_acc_ext = BASE_BITS'(col_accum_reg);
    assign row_hi      = row_base_reg + BASE_BITS'(fh_reg);
    assign col_hi      = col_base_reg + BASE_BITS'(fw_reg);

    assign row_sel = (fw_reg != '0) && (fh_reg != '0) && (out_row_reg < fh_reg)
                     && (row_acc_ext >= row_base_reg) && (row_acc_ext < row_hi);
    assign hit     = row_sel && (out_col_reg < fw_reg)
                     && (col_acc_ext >= col_base_reg) && (col_acc_ext < col_hi);
    assign is_last = (out_row_reg == fh_reg - 1'b1) && (out_col_reg == fw_reg - 1'b1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_NEED_FIT:
            begin
                if (head_valid)
                begin
                    state_next = BK_WAIT_FIT;
                end
            end
            BK_WAIT_FIT:
            begin
                if (fit_done)
                begin
                    state_next = BK_STREAM;
                end
            end
            BK_STREAM:
            begin
                if (step && head_item.flags.frame_end)
                begin
                    state_next = BK_NEED_FIT;
                end
            end
            default: state_next = BK_NEED_FIT;
        endcase
    end

    // Outputs
    always_comb
    begin
        fit_start     = (state_reg == BK_NEED_FIT) && head_valid;
        pop           = step;
        out_valid     = out_valid_reg;
        pixel_out     = pixel_reg;
        frame_last    = last_reg;
        fitted_width  = width_reg;
        fitted_height = height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_NEED_FIT;
            fw_reg        <= '0;
            fh_reg        <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            row_accum_reg <= '0;
            col_accum_reg <= '0;
            row_base_reg  <= '0;
            col_base_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Latch fitted size
            if ((state_reg == BK_WAIT_FIT) && fit_done)
            begin
                fw_reg <= fit_w;
                fh_reg <= fit_h;
            end

            // Hold or drop the output item
            if (step && hit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Advance frame position
            if (step)
            begin
                if (head_item.flags.frame_end)
                begin
                    fw_reg        <= '0;
                    fh_reg        <= '0;
                    out_row_reg   <= '0;
                    out_col_reg   <= '0;
                    row_accum_reg <= '0;
                    col_accum_reg <= '0;
                    row_base_reg  <= '0;
                    col_base_reg  <= '0;
                end
                else if (head_item.flags.row_end)
                begin
                    out_col_reg   <= '0;
                    col_accum_reg <= '0;
                    col_base_reg  <= '0;
                    row_base_reg  <= row_hi;
                    if (row_sel)
                    begin
                        out_row_reg   <= out_row_reg + 1'b1;
                        row_accum_reg <= row_accum_reg + ACC_BITS'(sh_eff);
                    end
                end
                else
                begin
                    col_base_reg <= col_hi;
                    if (hit)
                    begin
                        out_col_reg   <= out_col_reg + 1'b1;
                        col_accum_reg <= col_accum_reg + ACC_BITS'(sw_eff);
                    end
                end
            end
        end
    end

    // Load output payload
    always_ff @(posedge clk)
    begin
        if (step && hit)
        begin
            pixel_reg  <= head_item.pixel;
            last_reg   <= is_last;
            width_reg  <= fw_reg;
            height_reg <= fh_reg;
        end
    end

endmodule

// File: rtl/core/fit_to_page_nearest_downscaler.sv
// ----------------------------------------------------------------------------
// fit_to_page_nearest_downscaler
// Nearest-neighbor downscaler that fits a grey raster frame to the page.
// ----------------------------------------------------------------------------
// Usage:
//   Source pixels enter on in_valid/in_stall/pixel_in in raster order, one
//   frame being source_width x source_height pixels. Selected pixels leave
//   on out_valid/out_stall with pixel_out, frame_last and the fitted size.
//   Registers are written through cfg_write/cfg_index/cfg_data while no
//   item is in flight.
//   Within a frame the block takes one pixel per cycle while the output is
//   not stalled. An accepted pixel passes through the queue and the
//   output register before it shows at the output. On the first pixel
//   of each frame the fitted size is computed by a shared multiply and a
//   one-bit-per-cycle divider, so that pixel waits in the queue until the
//   fit is done; meanwhile up to four pixels queue up.
//   Reset clears the queue, the frame position and the output register and
//   restores the register defaults. A stalled output item holds; the queue
//   then fills and in_stall rises until the receiver takes the item.
// ----------------------------------------------------------------------------
module fit_to_page_nearest_downscaler #(
    parameter int DIM_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ftpnd_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]               cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ftpnd_pkg::PIXEL_BITS-1:0]  pixel_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ftpnd_pkg::PIXEL_BITS-1:0]  pixel_out,
    output logic                              frame_last,
    output logic [DIM_BITS-1:0]               fitted_width,
    output logic [DIM_BITS-1:0]               fitted_height
);

    import ftpnd_pkg::*;

    logic [DIM_BITS-1:0]   page_width_reg;
    logic [DIM_BITS-1:0]   page_height_reg;
    logic [GUARD_BITS-1:0] guard_size_reg;
    logic [DIM_BITS-1:0]   source_width_reg;
    logic [DIM_BITS-1:0]   source_height_reg;

    logic [DIM_BITS-1:0]   sw_eff;
    logic [DIM_BITS-1:0]   sh_eff;

    logic                  queue_full;
    logic                  queue_empty;
    logic                  push;
    queue_item_t           push_item;
    logic                  pop;
    logic [ITEM_BITS-1:0]  head_bits;
    queue_item_t           head_item;

    logic                  fit_start;
    logic                  fit_done;
    logic [DIM_BITS-1:0]   fit_w;
    logic [DIM_BITS-1:0]   fit_h;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_width_reg    <= DIM_BITS'(PAGE_WIDTH_RESET);
            page_height_reg   <= DIM_BITS'(PAGE_HEIGHT_RESET);
            guard_size_reg    <= GUARD_BITS'(GUARD_SIZE_RESET);
            source_width_reg  <= DIM_BITS'(SOURCE_WIDTH_RESET);
            source_height_reg <= DIM_BITS'(SOURCE_HEIGHT_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PAGE_WIDTH:    page_width_reg    <= cfg_data;
                REG_PAGE_HEIGHT:   page_height_reg   <= cfg_data;
                REG_GUARD_SIZE:    guard_size_reg    <= cfg_data[GUARD_BITS-1:0];
                REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                REG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                default:           page_width_reg    <= page_width_reg;
            endcase
        end
    end

    // Treat a zero source dimension as one
    assign sw_eff = (source_width_reg == '0)  ? DIM_BITS'(1) : source_width_reg;
    assign sh_eff = (source_height_reg == '0) ? DIM_BITS'(1) : source_height_reg;

    ftpnd_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_in   (pixel_in),
        .sw_eff     (sw_eff),
        .sh_eff     (sh_eff),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    ftpnd_queue #(
        .WIDTH (ITEM_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head_bits),
        .empty     (queue_empty)
    );

    assign head_item = queue_item_t'(head_bits);

    ftpnd_fit #(
        .DIM_BITS (DIM_BITS)
    ) u_fit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fit_start),
        .sw    (sw_eff),
        .sh    (sh_eff),
        .pw    (page_width_reg),
        .ph    (page_height_reg),
        .guard (guard_size_reg),
        .done  (fit_done),
        .fit_w (fit_w),
        .fit_h (fit_h)
    );

    ftpnd_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (!queue_empty),
        .head_item     (head_item),
        .pop           (pop),
        .sw_eff        (sw_eff),
        .sh_eff        (sh_eff),
        .fit_start     (fit_start),
        .fit_done      (fit_done),
        .fit_w         (fit_w),
        .fit_h         (fit_h),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_out     (pixel_out),
        .frame_last    (frame_last),
        .fitted_width  (fitted_width),
        .fitted_height (fitted_height)
    );

endmodule

// File: rtl/core/ftpnd_checker.sv
// ----------------------------------------------------------------------------
// ftpnd_checker
// Port-level checks of the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module ftpnd_checker #(
    parameter int DIM_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [ftpnd_pkg::PIXEL_BITS-1:0]  pixel_out,
    input  logic                              frame_last,
    input  logic [DIM_BITS-1:0]               fitted_width,
    input  logic [DIM_BITS-1:0]               fitted_height
);

    // A stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_last))
        else $error("stalled output item changed");

    // A zero fitted dimension never emits an item
    a_no_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fitted_width != '0) && (fitted_height != '0))
        else $error("item emitted for an empty fitted frame");

    // Fitted size stays fixed between items of one frame
    a_size_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !frame_last |=> !out_valid
            || ((fitted_width == $past(fitted_width))
                && (fitted_height == $past(fitted_height))))
        else $error("fitted size changed inside a frame");

    // Queue is open right after reset
    a_ready_after_reset: assert property (@(posedge clk)
        rst_n && $past(!rst_n) |-> !in_stall)
        else $error("input stalled right after reset");

endmodule

bind fit_to_page_nearest_downscaler ftpnd_checker #(
    .DIM_BITS (DIM_BITS)
) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_out     (pixel_out),
    .frame_last    (frame_last),
    .fitted_width  (fitted_width),
    .fitted_height (fitted_height)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fit-to-page nearest-neighbor downscaler.
// A directed table checks the corner cases: reset sizes, a zero source size,
// both shrink directions, a zero fitted size, a guard above the page, the
// largest frame and a source size cut down in the middle of a frame. Random
// frames then run under four idle/stall mixes. Every selected pixel is
// checked against a cycle-free fit and selection model or a typed row's result.
// ----------------------------------------------------------------------------
module tb;

    import ftpnd_pkg::*;

    localparam int DIM           = 12;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1500;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  last;
        logic [DIM-1:0]        width;
        logic [DIM-1:0]        height;
    } scaled_px_t;

    typedef enum bit {
        STEP_WRITE,
        STEP_PIXEL
    } step_kind_t;

    // One row of the directed plan; typed rows carry their own result
    typedef struct packed {
        step_kind_t     kind;
        cfg_reg_t       reg_id;
        logic [DIM-1:0] value;
        bit             typed;
        bit             has_px;
        scaled_px_t     px;
    } plan_row_t;

    localparam scaled_px_t NO_PX = '0;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = REG_PAGE_WIDTH;
    logic [DIM-1:0]        cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PIXEL_BITS-1:0] pixel_in = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  frame_last;
    logic [DIM-1:0]        fitted_width;
    logic [DIM-1:0]        fitted_height;

    fit_to_page_nearest_downscaler #(
        .DIM_BITS (DIM)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_in      (pixel_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_out     (pixel_out),
        .frame_last    (frame_last),
        .fitted_width  (fitted_width),
        .fitted_height (fitted_height)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies and frame state of the scaler model
    logic [DIM-1:0]        cfg_pw = DIM'(PAGE_WIDTH_RESET);
    logic [DIM-1:0]        cfg_ph = DIM'(PAGE_HEIGHT_RESET);
    logic [GUARD_BITS-1:0] cfg_guard = GUARD_BITS'(GUARD_SIZE_RESET);
    logic [DIM-1:0]        cfg_sw = DIM'(SOURCE_WIDTH_RESET);
    logic [DIM-1:0]        cfg_sh = DIM'(SOURCE_HEIGHT_RESET);

    bit               frame_open = 1'b0;
    logic [DIM-1:0]   fit_w = '0;
    logic [DIM-1:0]   fit_h = '0;
    logic [DIM-1:0]   src_r = '0;
    logic [DIM-1:0]   src_c = '0;
    logic [DIM-1:0]   out_r = '0;
    logic [DIM-1:0]   out_c = '0;
    logic [2*DIM-1:0] acc_r = '0;
    logic [2*DIM-1:0] acc_c = '0;

    scaled_px_t pending_px [$];
    int         err_count = 0;
    int         cycle_count = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    bit         pending_work = 1'b0;

    function automatic int unsigned eff_dim(input logic [DIM-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic longint unsigned shrink(input logic [DIM-1:0] page);
        return (page > cfg_guard) ? longint'(page - cfg_guard) : 0;
    endfunction

    // Advance the model by one source pixel; report the pixel it selects
    task automatic step_scaler(input logic [PIXEL_BITS-1:0] value, output bit hit,
                               output scaled_px_t px);
        longint unsigned sw64;
        longint unsigned sh64;
        longint unsigned nw;
        longint unsigned nh;
        int unsigned     sw;
        int unsigned     sh;
        bit              row_sel;
        hit = 1'b0;
        px = NO_PX;
        // Work out the fitted size on the first pixel of a frame
        if (!frame_open)
        begin
            sw64 = eff_dim(cfg_sw);
            sh64 = eff_dim(cfg_sh);
            if (sw64 > cfg_pw)
            begin
                nw = shrink(cfg_pw);
                nh = sh64 * nw / sw64;
                if (nh > cfg_ph)
                begin
                    nh = shrink(cfg_ph);
                    nw = sw64 * nh / sh64;
                end
            end
            else if (sh64 > cfg_ph)
            begin
                nh = shrink(cfg_ph);
                nw = sw64 * nh / sh64;
                if (nw > cfg_pw)
                begin
                    nw = shrink(cfg_pw);
                    nh = sh64 * nw / sw64;
                end
            end
            else
            begin
                nw = sw64;
                nh = sh64;
            end
            fit_w = DIM'(nw);
            fit_h = DIM'(nh);
            frame_open = 1'b1;
        end
        sw = eff_dim(cfg_sw);
        sh = eff_dim(cfg_sh);

        // Select the pixel when both accumulators point at it
        row_sel = 1'b0;
        if (fit_w != '0 && fit_h != '0 && out_r < fit_h)
            row_sel = (src_r == acc_r / fit_h);
        if (row_sel && out_c < fit_w && src_c == acc_c / fit_w)
        begin
            hit = 1'b1;
            px.pixel = value;
            px.last = (out_r == fit_h - 1 && out_c == fit_w - 1);
            px.width = fit_w;
            px.height = fit_h;
            out_c = out_c + 1'b1;
            acc_c = acc_c + sw;
        end

        // Advance the source position; clear everything at the end of frame
        if (src_c + 1 >= sw)
        begin
            if (src_r + 1 >= sh)
            begin
                frame_open = 1'b0;
                fit_w = '0;
                fit_h = '0;
                src_r = '0;
                src_c = '0;
                out_r = '0;
                out_c = '0;
                acc_r = '0;
                acc_c = '0;
            end
            else
            begin
                src_c = '0;
                src_r = src_r + 1'b1;
                out_c = '0;
                acc_c = '0;
                if (row_sel)
                begin
                    out_r = out_r + 1'b1;
                    acc_r = acc_r + sh;
                end
            end
        end
        else
        begin
            src_c = src_c + 1'b1;
        end
    endtask

    // Drop valid, drain all expected pixels, then let the fit logic go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        pending_work = 1'b0;
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [DIM-1:0] v);
        if (pending_work)
            settle();
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (r)
            REG_PAGE_WIDTH:    cfg_pw = v;
            REG_PAGE_HEIGHT:   cfg_ph = v;
            REG_GUARD_SIZE:    cfg_guard = v[GUARD_BITS-1:0];
            REG_SOURCE_WIDTH:  cfg_sw = v;
            REG_SOURCE_HEIGHT: cfg_sh = v;
            default: ;
        endcase
    endtask

    // Offer one source pixel after a random gap and hold it until taken
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] value, input bit typed,
                              input bit typed_hit, input scaled_px_t typed_px);
        bit         hit;
        scaled_px_t px;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        pixel_in <= value;
        do
            @(posedge clk);
        while (in_stall);
        step_scaler(value, hit, px);
        if (typed)
        begin
            hit = typed_hit;
            px = typed_px;
        end
        if (hit)
            pending_px.push_back(px);
        pending_work = 1'b1;
    endtask

    function automatic logic [DIM-1:0] pick_page();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        if (roll < 9)
            return '1;
        return DIM'($urandom_range(1, 20));
    endfunction

    function automatic logic [DIM-1:0] pick_source();
        if ($urandom_range(99) < 5)
            return '0;
        return DIM'($urandom_range(1, 16));
    endfunction

    function automatic logic [DIM-1:0] pick_guard();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll < 6)
            return DIM'($urandom_range(3));
        if (roll < 8)
            return DIM'($urandom_range(20));
        return DIM'($urandom_range(255));
    endfunction

    // Take output items under random stall and check them in order
    always @(posedge clk)
    begin : rx_check
        scaled_px_t got;
        scaled_px_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{pixel_out, frame_last, fitted_width, fitted_height};
            if (pending_px.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected item pixel=%h last=%b size=%0dx%0d",
                         $time, pixel_out, frame_last, fitted_width, fitted_height);
            end
            else
            begin
                want = pending_px.pop_front();
                if (got !== want)
                begin
                    err_count++;
                    $display("%0t: expected pixel=%h last=%b size=%0dx%0d, got pixel=%h last=%b size=%0dx%0d",
                             $time, want.pixel, want.last, want.width, want.height,
                             got.pixel, got.last, got.width, got.height);
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        plan_row_t plan [$];
        int        random_items;
        int        block_no;
        int        frame_px;

        plan = '{
            // Reset sizes: a 1x1 frame passes straight through
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h000, 1'b1, 1'b1, '{8'h00, 1'b1, 12'd1, 12'd1}},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h0FF, 1'b1, 1'b1, '{8'hFF, 1'b1, 12'd1, 12'd1}},
            // Zero source width counts as one
            '{STEP_WRITE, REG_SOURCE_WIDTH, 12'd0, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h05A, 1'b1, 1'b1, '{8'h5A, 1'b1, 12'd1, 12'd1}},
            // Too wide: 4x2 onto a page 2 wide gives 2x1
            '{STEP_WRITE, REG_SOURCE_WIDTH, 12'd4, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_SOURCE_HEIGHT, 12'd2, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_PAGE_WIDTH, 12'd2, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h001, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h002, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h004, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h008, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h010, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h020, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h040, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h080, 1'b0, 1'b0, NO_PX},
            // Too tall: width scales down to zero, nothing comes out
            '{STEP_WRITE, REG_SOURCE_WIDTH, 12'd1, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_SOURCE_HEIGHT, 12'd4, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_PAGE_HEIGHT, 12'd2, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h011, 1'b1, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h022, 1'b1, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h044, 1'b1, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h088, 1'b1, 1'b0, NO_PX},
            // Guard above the page: shrunk width saturates at zero
            '{STEP_WRITE, REG_GUARD_SIZE, 12'd255, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_SOURCE_WIDTH, 12'd4, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_SOURCE_HEIGHT, 12'd1, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h0EE, 1'b1, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h0DD, 1'b1, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h0BB, 1'b1, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h077, 1'b1, 1'b0, NO_PX},
            // Largest frame fits the largest page as it is
            '{STEP_WRITE, REG_PAGE_WIDTH, 12'd4095, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_PAGE_HEIGHT, 12'd4095, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_GUARD_SIZE, 12'd0, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_SOURCE_WIDTH, 12'd4095, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_SOURCE_HEIGHT, 12'd4095, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h03C, 1'b1, 1'b1, '{8'h3C, 1'b0, 12'd4095, 12'd4095}},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h0C3, 1'b1, 1'b1, '{8'hC3, 1'b0, 12'd4095, 12'd4095}},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h081, 1'b1, 1'b1, '{8'h81, 1'b0, 12'd4095, 12'd4095}},
            // Cut the source size mid-frame: the next pixel ends the frame
            '{STEP_WRITE, REG_SOURCE_WIDTH, 12'd1, 1'b0, 1'b0, NO_PX},
            '{STEP_WRITE, REG_SOURCE_HEIGHT, 12'd1, 1'b0, 1'b0, NO_PX},
            '{STEP_PIXEL, REG_PAGE_WIDTH, 12'h07E, 1'b0, 1'b0, NO_PX}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan with light idling on both sides
        idle_pct = 28;
        stall_pct = 28;
        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_WRITE)
                write_reg(plan[i].reg_id, plan[i].value);
            else
                send_pixel(plan[i].value[PIXEL_BITS-1:0], plan[i].typed,
                           plan[i].has_px, plan[i].px);
        end

        // Random frames, rotating through the idle/stall mixes
        random_items = 0;
        block_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (block_no % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            block_no++;
            if ($urandom_range(7) == 0)
            begin
                // Broken frame: full-range sizes, cut short by a mid-frame resize
                write_reg(REG_PAGE_WIDTH, DIM'($urandom_range(4095)));
                write_reg(REG_PAGE_HEIGHT, DIM'($urandom_range(4095)));
                write_reg(REG_GUARD_SIZE, DIM'($urandom_range(4095)));
                write_reg(REG_SOURCE_WIDTH, DIM'($urandom_range(4095)));
                write_reg(REG_SOURCE_HEIGHT, DIM'($urandom_range(4095)));
                repeat ($urandom_range(1, 20))
                begin
                    send_pixel(PIXEL_BITS'($urandom_range(255)), 1'b0, 1'b0, NO_PX);
                    random_items++;
                end
                write_reg(REG_SOURCE_WIDTH, DIM'($urandom_range(1, 4)));
                write_reg(REG_SOURCE_HEIGHT, DIM'($urandom_range(1, 4)));
                while (frame_open)
                begin
                    send_pixel(PIXEL_BITS'($urandom_range(255)), 1'b0, 1'b0, NO_PX);
                    random_items++;
                end
            end
            else
            begin
                // Well-formed frames of small random sizes
                write_reg(REG_PAGE_WIDTH, pick_page());
                write_reg(REG_PAGE_HEIGHT, pick_page());
                write_reg(REG_GUARD_SIZE, pick_guard());
                write_reg(REG_SOURCE_WIDTH, pick_source());
                write_reg(REG_SOURCE_HEIGHT, pick_source());
                frame_px = eff_dim(cfg_sw) * eff_dim(cfg_sh);
                repeat ($urandom_range(1, 3))
                begin
                    repeat (frame_px)
                        send_pixel(PIXEL_BITS'($urandom_range(255)), 1'b0, 1'b0, NO_PX);
                    random_items += frame_px;
                end
            end
        end

        settle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
